### rtl/core/windowed_frequency_eviction_ranker_macros.svh
// Assertion helpers used by the ranker top level.
`ifndef WINDOWED_FREQUENCY_EVICTION_RANKER_MACROS_SVH
`define WINDOWED_FREQUENCY_EVICTION_RANKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WFER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WFER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wfer_pkg.sv
package wfer_pkg;

    localparam int DEF_WINDOW_DEPTH = 1024;
    localparam int DEF_MAX_EVICT    = 64;

    localparam int KEY_W    = 64;
    localparam int LIM_W    = 7;
    localparam int ACNT_W   = 11;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 80;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic rec;
        logic start;
        logic cnt_rd;
        logic cnt_latch;
        logic cnt_skip;
        logic ins;
        logic srch_rd;
        logic srch_upd;
        logic srch_next;
        logic sel_init;
        logic sel_rd;
        logic sel_cmp;
        logic sel_pick;
        logic sel_key;
        logic ev_rd;
        logic ev_chk;
        logic emit;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_end;
        logic key_zero;
        logic srch_end;
        logic srch_hit;
        logic lim_end;
        logic sel_end;
        logic best_v;
        logic out_free;
    } status_t;

endpackage

### rtl/core/wfer_ram.sv
module wfer_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/wfer_ctrl.sv
module wfer_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_mode,
    input  wfer_pkg::status_t st,
    output logic             in_ready,
    output wfer_pkg::cmd_t   cmd
);
    import wfer_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CNT_RD    = 4'd1;
    localparam logic [3:0] S_CNT_WAIT  = 4'd2;
    localparam logic [3:0] S_SRCH_RD   = 4'd3;
    localparam logic [3:0] S_SRCH_WAIT = 4'd4;
    localparam logic [3:0] S_SEL_INIT  = 4'd5;
    localparam logic [3:0] S_SEL_RD    = 4'd6;
    localparam logic [3:0] S_SEL_WAIT  = 4'd7;
    localparam logic [3:0] S_SEL_DONE  = 4'd8;
    localparam logic [3:0] S_SEL_KEY   = 4'd9;
    localparam logic [3:0] S_EV_RD     = 4'd10;
    localparam logic [3:0] S_EV_WAIT   = 4'd11;
    localparam logic [3:0] S_EMIT      = 4'd12;
    localparam logic [3:0] S_FINISH    = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Sequencer for the count, select and evict passes.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_CNT_RD;
                    end
                    else
                    begin
                        cmd.rec = 1'b1;
                    end
                end
            end
            S_CNT_RD:
            begin
                if (st.cnt_end)
                begin
                    state_next = S_SEL_INIT;
                end
                else
                begin
                    cmd.cnt_rd = 1'b1;
                    state_next = S_CNT_WAIT;
                end
            end
            S_CNT_WAIT:
            begin
                cmd.cnt_latch = 1'b1;
                if (st.key_zero)
                begin
                    cmd.cnt_skip = 1'b1;
                    state_next   = S_CNT_RD;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (st.srch_end)
                begin
                    cmd.ins    = 1'b1;
                    state_next = S_CNT_RD;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_WAIT;
                end
            end
            S_SRCH_WAIT:
            begin
                if (st.srch_hit)
                begin
                    cmd.srch_upd = 1'b1;
                    state_next   = S_CNT_RD;
                end
                else
                begin
                    cmd.srch_next = 1'b1;
                    state_next    = S_SRCH_RD;
                end
            end
            S_SEL_INIT:
            begin
                if (st.lim_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.sel_init = 1'b1;
                    state_next   = S_SEL_RD;
                end
            end
            S_SEL_RD:
            begin
                if (st.sel_end)
                begin
                    state_next = S_SEL_DONE;
                end
                else
                begin
                    cmd.sel_rd = 1'b1;
                    state_next = S_SEL_WAIT;
                end
            end
            S_SEL_WAIT:
            begin
                cmd.sel_cmp = 1'b1;
                state_next  = S_SEL_RD;
            end
            S_SEL_DONE:
            begin
                if (st.best_v)
                begin
                    cmd.sel_pick = 1'b1;
                    state_next   = S_SEL_KEY;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SEL_KEY:
            begin
                cmd.sel_key = 1'b1;
                state_next  = S_EV_RD;
            end
            S_EV_RD:
            begin
                if (st.cnt_end)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.ev_rd  = 1'b1;
                    state_next = S_EV_WAIT;
                end
            end
            S_EV_WAIT:
            begin
                cmd.ev_chk = 1'b1;
                state_next = S_EV_RD;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_SEL_INIT;
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/wfer_dp.sv
module wfer_dp #(
    parameter int WINDOW_DEPTH = wfer_pkg::DEF_WINDOW_DEPTH,
    parameter int MAX_EVICT    = wfer_pkg::DEF_MAX_EVICT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wfer_pkg::cmd_t                cmd,
    input  logic [wfer_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          m_tready,
    output wfer_pkg::status_t             st,
    output logic                          m_tvalid,
    output logic [wfer_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import wfer_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = FW + 1;
    localparam int EW = (FW > ACNT_W) ? FW : ACNT_W;
    localparam int CW = FW + 1;

    // Input word fields.
    logic [KEY_W-1:0] in_key;
    logic [LIM_W-1:0] in_lim;
    logic             in_mff;
    assign in_key = s_tdata[KEY_W-1:0];
    assign in_lim = s_tdata[KEY_W+LIM_W-1:KEY_W];
    assign in_mff = s_tdata[KEY_W+LIM_W];

    logic [AW-1:0]    head_reg;
    logic [FW-1:0]    fill_reg;
    logic [AW-1:0]    start_reg;
    logic [AW-1:0]    slot_reg;
    logic [FW-1:0]    idx_reg;
    logic [FW-1:0]    dcnt_reg;
    logic [FW-1:0]    j_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [LIM_W-1:0] r_reg;
    logic             mff_reg;
    logic [KEY_W-1:0] cur_reg;
    logic [FW-1:0]    best_reg;
    logic [FW-1:0]    bc_reg;
    logic             bv_reg;
    logic [KEY_W-1:0] pend_key_reg;
    logic [FW-1:0]    pend_cnt_reg;
    logic             pend_v_reg;
    logic             out_v_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic [ACNT_W-1:0] out_cnt_reg;
    logic             out_res_reg;
    logic             out_last_reg;

    logic [KEY_W-1:0] wm_rdata;
    logic [KEY_W-1:0] dk_rdata;
    logic [CW-1:0]    dc_rdata;

    logic [SW-1:0]    start_sum;
    logic [AW-1:0]    start_slot;
    logic [LIM_W-1:0] lim_clamp;
    logic [AW-1:0]    slot_inc;
    logic [AW-1:0]    head_inc;
    logic             dc_chosen;
    logic [FW-1:0]    dc_cnt;
    logic             better;
    logic             ev_hit;
    logic [EW-1:0]    pend_ext;
    logic [ACNT_W-1:0] pend_sat;

    // Oldest slot of the window and wrapping slot increments.
    assign start_sum  = SW'(head_reg) + SW'(WINDOW_DEPTH) - SW'(fill_reg);
    assign start_slot = (start_sum >= SW'(WINDOW_DEPTH)) ?
                        AW'(start_sum - SW'(WINDOW_DEPTH)) : AW'(start_sum);
    assign slot_inc   = (slot_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    assign head_inc   = (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign lim_clamp  = (in_lim > LIM_W'(MAX_EVICT)) ? LIM_W'(MAX_EVICT) : in_lim;

    // Candidate compare; equal counts keep the earlier key.
    assign dc_chosen = dc_rdata[CW-1];
    assign dc_cnt    = dc_rdata[FW-1:0];
    assign better    = !dc_chosen &&
                       (!bv_reg || (mff_reg ? (dc_cnt > bc_reg) : (dc_cnt < bc_reg)));
    assign ev_hit    = (wm_rdata == cur_reg);

    // Count saturation on the result word.
    assign pend_ext = EW'(pend_cnt_reg);
    assign pend_sat = (pend_ext > EW'(2047)) ? {ACNT_W{1'b1}} : pend_ext[ACNT_W-1:0];

    // Window store.
    wfer_ram #(.WIDTH(KEY_W), .DEPTH(WINDOW_DEPTH)) u_window (
        .clk   (clk),
        .we    (cmd.rec || (cmd.ev_chk && ev_hit)),
        .waddr (cmd.rec ? head_reg : slot_reg),
        .wdata (cmd.rec ? in_key : '0),
        .re    (cmd.cnt_rd || cmd.ev_rd),
        .raddr (slot_reg),
        .rdata (wm_rdata)
    );

    // Distinct key table.
    wfer_ram #(.WIDTH(KEY_W), .DEPTH(WINDOW_DEPTH)) u_dkey (
        .clk   (clk),
        .we    (cmd.ins),
        .waddr (dcnt_reg[AW-1:0]),
        .wdata (cur_reg),
        .re    (cmd.srch_rd || cmd.sel_pick),
        .raddr (cmd.sel_pick ? best_reg[AW-1:0] : j_reg[AW-1:0]),
        .rdata (dk_rdata)
    );

    // Distinct count table with the chosen mark on top.
    logic [AW-1:0] dc_waddr;
    logic [CW-1:0] dc_wdata;
    always_comb
    begin
        dc_waddr = dcnt_reg[AW-1:0];
        dc_wdata = {1'b0, FW'(1)};
        if (cmd.srch_upd)
        begin
            dc_waddr = j_reg[AW-1:0];
            dc_wdata = {1'b0, dc_cnt + 1'b1};
        end
        else if (cmd.sel_pick)
        begin
            dc_waddr = best_reg[AW-1:0];
            dc_wdata = {1'b1, bc_reg};
        end
    end

    wfer_ram #(.WIDTH(CW), .DEPTH(WINDOW_DEPTH)) u_dcnt (
        .clk   (clk),
        .we    (cmd.ins || cmd.srch_upd || cmd.sel_pick),
        .waddr (dc_waddr),
        .wdata (dc_wdata),
        .re    (cmd.srch_rd || cmd.sel_rd),
        .raddr (j_reg[AW-1:0]),
        .rdata (dc_rdata)
    );

    // Window pointers, pass counters and selection registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            fill_reg   <= '0;
            start_reg  <= '0;
            slot_reg   <= '0;
            idx_reg    <= '0;
            dcnt_reg   <= '0;
            j_reg      <= '0;
            lim_reg    <= '0;
            r_reg      <= '0;
            mff_reg    <= 1'b0;
            best_reg   <= '0;
            bc_reg     <= '0;
            bv_reg     <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rec)
            begin
                head_reg <= head_inc;
                if (fill_reg != FW'(WINDOW_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.start)
            begin
                start_reg  <= start_slot;
                slot_reg   <= start_slot;
                idx_reg    <= '0;
                dcnt_reg   <= '0;
                lim_reg    <= lim_clamp;
                r_reg      <= '0;
                mff_reg    <= in_mff;
                pend_v_reg <= 1'b0;
            end
            if (cmd.cnt_latch)
            begin
                j_reg <= '0;
            end
            if (cmd.cnt_skip || cmd.ins || cmd.srch_upd || cmd.ev_chk)
            begin
                idx_reg  <= idx_reg + 1'b1;
                slot_reg <= slot_inc;
            end
            if (cmd.ins)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (cmd.srch_next || cmd.sel_cmp)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (cmd.sel_init)
            begin
                j_reg  <= '0;
                bv_reg <= 1'b0;
            end
            if (cmd.sel_cmp && better)
            begin
                best_reg <= j_reg;
                bc_reg   <= dc_cnt;
                bv_reg   <= 1'b1;
            end
            if (cmd.sel_key)
            begin
                idx_reg  <= '0;
                slot_reg <= start_reg;
            end
            if (cmd.emit)
            begin
                pend_v_reg <= 1'b1;
                r_reg      <= r_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                pend_v_reg <= 1'b0;
            end
        end
    end

    // Current key and pending victim payload.
    always_ff @(posedge clk)
    begin
        if (cmd.cnt_latch)
        begin
            cur_reg <= wm_rdata;
        end
        if (cmd.sel_key)
        begin
            cur_reg <= dk_rdata;
        end
        if (cmd.emit)
        begin
            pend_key_reg <= cur_reg;
            pend_cnt_reg <= bc_reg;
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if ((cmd.emit && pend_v_reg) || cmd.finish)
        begin
            out_v_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.emit && pend_v_reg) || cmd.finish)
        begin
            out_key_reg  <= pend_v_reg ? pend_key_reg : '0;
            out_cnt_reg  <= pend_v_reg ? pend_sat : '0;
            out_res_reg  <= pend_v_reg;
            out_last_reg <= cmd.finish;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = M_DATA_W'({out_cnt_reg, out_key_reg});
    assign m_tuser  = out_res_reg;
    assign m_tlast  = out_last_reg;

    // Status back to the controller.
    assign st.cnt_end  = (idx_reg == fill_reg);
    assign st.key_zero = (wm_rdata == '0);
    assign st.srch_end = (j_reg == dcnt_reg);
    assign st.srch_hit = (dk_rdata == cur_reg);
    assign st.lim_end  = (r_reg == lim_reg);
    assign st.sel_end  = (j_reg == dcnt_reg);
    assign st.best_v   = bv_reg;
    assign st.out_free = !out_v_reg || m_tready;

endmodule

### rtl/core/windowed_frequency_eviction_ranker.sv
// Channel  Dir  tdata (low bit first)                          tuser         tlast
// s_*      in   key[63:0], evict_limit[70:64], mff[71]         mode          -
// m_*      out  victim_key[63:0], access_count[74:64], pad     valid_res     last
//
// A record word leaves the sequencer in idle; the block is ready again on the next cycle.
// A rank word walks the window through one RAM read port: a count pass over the
// W filled slots and D distinct keys, then for each victim a select scan and an
// eviction sweep of the window.
// Reset clears pointers and control only; a fill count marks the written slots.
// A stalled output holds the sequencer at its emit or finish step; records wait for idle.
module windowed_frequency_eviction_ranker #(
    parameter int WINDOW_DEPTH = wfer_pkg::DEF_WINDOW_DEPTH,
    parameter int MAX_EVICT    = wfer_pkg::DEF_MAX_EVICT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wfer_pkg::S_DATA_W-1:0] s_tdata,   // key, evict_limit, most_frequent_first
    input  logic                          s_tuser,   // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wfer_pkg::M_DATA_W-1:0] m_tdata,   // victim_key, access_count, zero pad
    output logic                          m_tuser,   // valid_res
    output logic                          m_tlast
);
    import wfer_pkg::*;

    cmd_t    cmd;
    status_t st;

    wfer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .st       (st),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    wfer_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_EVICT    (MAX_EVICT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`include "windowed_frequency_eviction_ranker_macros.svh"

    // Window writes from records happen only on an accepted word.
    `WFER_ASSERT_NOW(a_rec_on_accept, cmd.rec, s_tvalid && s_tready && !s_tuser, "record without accept")
    // An empty result always closes its rank request.
    `WFER_ASSERT_NOW(a_empty_is_last, m_tvalid && !m_tuser, m_tlast, "empty result not last")
    // The closing step always presents a last word next.
    `WFER_ASSERT_NEXT(a_finish_last, cmd.finish, m_tvalid && m_tlast, "finish without last word")

endmodule
